// ===== src/bkv_pkg.sv =====
package bkv_pkg;

	// Frame size limits, counted with the terminating slot as in the protocol spec
	localparam int KEY_BYTES   = 8;
	localparam int VALUE_BYTES = 32;
	localparam int KEY_CHARS   = KEY_BYTES - 1;
	localparam int VALUE_CHARS = VALUE_BYTES - 1;

	// Counter wide enough for the longer of key and value
	localparam int CNT_W  = $clog2((VALUE_BYTES > KEY_BYTES) ? VALUE_BYTES : KEY_BYTES);
	// Stored key length, 0..KEY_CHARS
	localparam int KLEN_W = $clog2(KEY_BYTES);

	// Fixed result field widths
	localparam int KEY_TEXT_W = 56;

	// Printable range and delimiters
	localparam logic [7:0] CH_LOW    = 8'h21;
	localparam logic [7:0] CH_HIGH   = 8'h7E;
	localparam logic [7:0] CH_OPEN   = 8'h7B;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_CLOSE  = 8'h7D;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_KEY   = 2'd1,
		PH_VALUE = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE  = 3'd0,
		EV_START = 3'd1,
		EV_KEYCH = 3'd2,
		EV_VALCH = 3'd3,
		EV_MORE  = 3'd4,
		EV_LAST  = 3'd5,
		EV_DROP  = 3'd6
	} event_t;

	// Next state and key store controls from the step logic
	typedef struct packed {
		phase_t            phase;
		logic [CNT_W-1:0]  cnt;
		logic              key_wr;
		logic              key_clr;
	} step_ctl_t;

	// One result item
	typedef struct packed {
		event_t                  ev;
		logic [7:0]              ch;
		logic [4:0]              pos;
		logic [KEY_TEXT_W-1:0]   key;
		logic [2:0]              klen;
		logic [4:0]              vlen;
	} result_t;

endpackage

// ===== src/brace_key_value_frame_parser_core.sv =====
// Channel  Handshake            Payload
// -------  -------------------  -----------------------------------------------
// in       in_valid / in_stall  rx_byte
// out      out_valid/ out_stall event_res, char_out, char_pos, key_text,
//                               key_length, value_length
//
// One item per cycle sustained while out_stall is low; an accepted input passes
// through the input register and then the result register.
// arst_n clears the phase, the count and both valid flags; the key store
// and key length are loaded before any pair can report them.
// A stalled result holds; one more item can wait in the input register
// before in_stall rises.
module brace_key_value_frame_parser_core
	import bkv_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [7:0]              rx_byte,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [2:0]              event_res,
	output logic [7:0]              char_out,
	output logic [4:0]              char_pos,
	output logic [KEY_TEXT_W-1:0]   key_text,
	output logic [2:0]              key_length,
	output logic [4:0]              value_length
);

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	phase_t                 phase_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [7:0]             key_q [KEY_CHARS];
	logic [KLEN_W-1:0]      klen_q;
	logic                   out_valid_q;
	result_t                res_q;

	logic                   out_free;
	logic                   in_fire;
	logic                   fire_s1;
	logic [KEY_TEXT_W-1:0]  key_packed;
	step_ctl_t              ctl;
	result_t                res;

	// Handshake
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !out_free;
	assign in_fire  = in_valid && !in_stall;
	assign fire_s1  = valid_s1 && out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= rx_byte;
		end
	end

	// Pack stored key, first char in the low byte
	always_comb begin
		key_packed = '0;
		for (int i = 0; i < KEY_CHARS; i++) begin
			key_packed[8*i +: 8] = key_q[i];
		end
	end

	bkv_step u_step (
		.rx_c       (byte_s1),
		.phase      (phase_q),
		.cnt        (cnt_q),
		.key_packed (key_packed),
		.klen       (klen_q),
		.ctl        (ctl),
		.res        (res)
	);

	// Advance phase and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
		end else if (fire_s1) begin
			phase_q <= ctl.phase;
			cnt_q   <= ctl.cnt;
		end
	end

	// Store key chars; on colon clear past the key and latch its length
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			for (int i = 0; i < KEY_CHARS; i++) begin
				if (ctl.key_wr && cnt_q == CNT_W'(i)) begin
					key_q[i] <= byte_s1;
				end else if (ctl.key_clr && cnt_q <= CNT_W'(i)) begin
					key_q[i] <= '0;
				end
			end
			if (ctl.key_clr) begin
				klen_q <= KLEN_W'(cnt_q);
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_free) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_res    = res_q.ev;
	assign char_out     = res_q.ch;
	assign char_pos     = res_q.pos;
	assign key_text     = res_q.key;
	assign key_length   = res_q.klen;
	assign value_length = res_q.vlen;

`ifndef SYNTHESIS
	a_idle_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> cnt_q == '0)
		else $error("count not cleared outside a frame");

	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 |=> out_valid)
		else $error("processed item produced no result");

	a_keych_in_key: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && res_q.ev == EV_KEYCH |-> phase_q == PH_KEY && cnt_q != '0)
		else $error("key char reported outside key phase");

	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (res_q.ev == EV_LAST || res_q.ev == EV_DROP) |-> phase_q == PH_IDLE)
		else $error("frame still open after close or drop");
`endif

endmodule

// ===== src/bkv_step.sv =====
module bkv_step
	import bkv_pkg::*;
(
	input  logic [7:0]              rx_c,
	input  phase_t                  phase,
	input  logic [CNT_W-1:0]        cnt,
	input  logic [KEY_TEXT_W-1:0]   key_packed,
	input  logic [KLEN_W-1:0]       klen,
	output step_ctl_t               ctl,
	output result_t                 res
);

	logic in_frame;
	logic printable;
	logic key_full;
	logic val_full;

	assign in_frame  = (phase == PH_KEY) || (phase == PH_VALUE);
	assign printable = rx_c inside {[CH_LOW:CH_HIGH]};
	assign key_full  = cnt >= CNT_W'(KEY_CHARS);
	assign val_full  = cnt >= CNT_W'(VALUE_CHARS);

	// Next phase, count and key store controls
	always_comb begin
		ctl.phase   = PH_IDLE;
		ctl.cnt     = '0;
		ctl.key_wr  = 1'b0;
		ctl.key_clr = 1'b0;
		case (rx_c)
			CH_OPEN: begin
				if (!in_frame) begin
					ctl.phase = PH_KEY;
				end
			end
			CH_COLON: begin
				if (phase == PH_KEY) begin
					ctl.phase   = PH_VALUE;
					ctl.key_clr = 1'b1;
				end
			end
			CH_COMMA, CH_CLOSE: begin
				if (phase == PH_VALUE && rx_c == CH_COMMA) begin
					ctl.phase = PH_KEY;
				end
			end
			default: begin
				if (printable) begin
					case (phase)
						PH_KEY: begin
							if (!key_full) begin
								ctl.phase  = PH_KEY;
								ctl.cnt    = cnt + CNT_W'(1);
								ctl.key_wr = 1'b1;
							end
						end
						PH_VALUE: begin
							if (!val_full) begin
								ctl.phase = PH_VALUE;
								ctl.cnt   = cnt + CNT_W'(1);
							end
						end
						default: begin
							ctl.phase = PH_IDLE;
						end
					endcase
				end
			end
		endcase
	end

	// Result item
	always_comb begin
		res     = '0;
		res.ev  = in_frame ? EV_DROP : EV_NONE;
		case (rx_c)
			CH_OPEN: begin
				if (!in_frame) begin
					res.ev = EV_START;
				end
			end
			CH_COLON: begin
				if (phase == PH_KEY) begin
					res.ev = EV_NONE;
				end
			end
			CH_COMMA, CH_CLOSE: begin
				if (phase == PH_VALUE) begin
					res.ev   = (rx_c == CH_COMMA) ? EV_MORE : EV_LAST;
					res.key  = key_packed;
					res.klen = 3'(klen);
					res.vlen = 5'(cnt);
				end
			end
			default: begin
				if (printable) begin
					case (phase)
						PH_KEY: begin
							if (!key_full) begin
								res.ev  = EV_KEYCH;
								res.ch  = rx_c;
								res.pos = 5'(cnt);
							end
						end
						PH_VALUE: begin
							if (!val_full) begin
								res.ev  = EV_VALCH;
								res.ch  = rx_c;
								res.pos = 5'(cnt);
							end
						end
						default: begin
							res.ev = EV_NONE;
						end
					endcase
				end
			end
		endcase
	end

endmodule
